FILE: rtl/bes_pkg.sv
// Shared types, constants and helpers for the burst error statistics block.
// Used by bes_front, bes_queue, bes_back and burst_error_statistics.
`default_nettype none
package bes_pkg;

  localparam int SAMPLE_DEPTH = 4096;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int HELD_W       = $clog2(SAMPLE_DEPTH + 1);
  localparam int CNT_W        = 48;
  localparam int LEN_W        = 32;
  localparam int NUM_BINS     = 7;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  // Opcodes of the input item.
  localparam logic [2:0] OP_GOOD     = 3'd0;
  localparam logic [2:0] OP_LOST     = 3'd1;
  localparam logic [2:0] OP_CLOSE    = 3'd2;
  localparam logic [2:0] OP_RD_COUNT = 3'd3;
  localparam logic [2:0] OP_RD_SMP   = 3'd4;

  // Counter selects: the last histogram bin and the counters above the bins.
  localparam logic [3:0] SEL_BIN_LAST    = 4'd6;
  localparam logic [3:0] SEL_BURSTS      = 4'd7;
  localparam logic [3:0] SEL_SUM         = 4'd8;
  localparam logic [3:0] SEL_LONGEST     = 4'd9;
  localparam logic [3:0] SEL_RECOVERABLE = 4'd10;
  localparam logic [3:0] SEL_CRITICAL    = 4'd11;
  localparam logic [3:0] SEL_SYMBOLS     = 4'd12;
  localparam logic [3:0] SEL_LOST        = 4'd13;

  // Upper edges of the histogram bins.
  localparam logic [LEN_W-1:0] BIN0_TOP = LEN_W'(1);
  localparam logic [LEN_W-1:0] BIN1_TOP = LEN_W'(5);
  localparam logic [LEN_W-1:0] BIN2_TOP = LEN_W'(10);
  localparam logic [LEN_W-1:0] BIN3_TOP = LEN_W'(50);
  localparam logic [LEN_W-1:0] BIN4_TOP = LEN_W'(100);
  localparam logic [LEN_W-1:0] BIN5_TOP = LEN_W'(500);

  // One classified item, passed from the front to the back.
  typedef struct packed {
    logic                 count_symbol;
    logic                 count_lost;
    logic                 closed;
    logic [LEN_W-1:0]     closed_length;
    logic [2:0]           bucket;
    logic                 critical;
    logic                 store;
    logic                 drop;
    logic [SAMPLE_AW-1:0] store_addr;
    logic [LEN_W-1:0]     current_length;
    logic                 rd_count;
    logic [3:0]           counter_select;
    logic                 rd_sample;
    logic [SAMPLE_AW-1:0] sample_index;
  } entry_t;

  function automatic logic [2:0] bin_of(input logic [LEN_W-1:0] len);
    logic [2:0] b;
    if (len <= BIN0_TOP) b = 3'd0;
    else if (len <= BIN1_TOP) b = 3'd1;
    else if (len <= BIN2_TOP) b = 3'd2;
    else if (len <= BIN3_TOP) b = 3'd3;
    else if (len <= BIN4_TOP) b = 3'd4;
    else if (len <= BIN5_TOP) b = 3'd5;
    else b = 3'd6;
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bes_front.sv
// Front part: accepts items, tracks the open run and the sample fill level,
// and classifies each item into a bes_pkg::entry_t for the queue.
`default_nettype none
module bes_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [31:0]            cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             opcode,
  input  wire logic [3:0]             counter_select,
  input  wire logic [11:0]            sample_index,
  input  wire logic                   q_full,
  output logic                        q_push,
  output bes_pkg::entry_t             q_data
);

  logic [bes_pkg::LEN_W-1:0]  span_limit;
  logic [bes_pkg::LEN_W-1:0]  run_length;
  logic [bes_pkg::LEN_W-1:0]  run_length_next;
  logic [bes_pkg::HELD_W-1:0] samples_held;
  logic [bes_pkg::HELD_W-1:0] samples_held_next;
  logic                       closing;
  bes_pkg::entry_t            e;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_data   = e;

  always_comb begin
    e                 = '0;
    closing           = 1'b0;
    run_length_next   = run_length;
    samples_held_next = samples_held;
    e.counter_select  = counter_select;
    e.sample_index    = bes_pkg::SAMPLE_AW'(sample_index);
    case (opcode)
      bes_pkg::OP_GOOD: begin
        e.count_symbol = 1'b1;
        closing        = (run_length != '0);
      end
      bes_pkg::OP_LOST: begin
        e.count_symbol = 1'b1;
        e.count_lost   = 1'b1;
        if (run_length != '1) run_length_next = run_length + 1'b1;
      end
      bes_pkg::OP_CLOSE: begin
        closing = (run_length != '0);
      end
      bes_pkg::OP_RD_COUNT: begin
        e.rd_count = 1'b1;
      end
      bes_pkg::OP_RD_SMP: begin
        // Entries at or above the fill level read as empty.
        e.rd_sample = (bes_pkg::HELD_W'(sample_index) < samples_held);
      end
      default: begin
      end
    endcase
    if (closing) begin
      e.closed        = 1'b1;
      e.closed_length = run_length;
      e.bucket        = bes_pkg::bin_of(run_length);
      e.critical      = (span_limit != '0) && (run_length > span_limit);
      e.store         = (samples_held < bes_pkg::HELD_W'(bes_pkg::SAMPLE_DEPTH));
      e.drop          = !e.store;
      e.store_addr    = samples_held[bes_pkg::SAMPLE_AW-1:0];
      run_length_next = '0;
      if (e.store) samples_held_next = samples_held + 1'b1;
    end
    e.current_length = run_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit   <= '0;
      run_length   <= '0;
      samples_held <= '0;
    end else begin
      if (cfg_we) span_limit <= cfg_wdata;
      if (q_push) begin
        run_length   <= run_length_next;
        samples_held <= samples_held_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bes_queue.sv
// Short FIFO of classified items between the front and the back parts.
// Depends on bes_pkg for the entry type and depth.
`default_nettype none
module bes_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bes_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output bes_pkg::entry_t      pop_data
);

  bes_pkg::entry_t              slots [bes_pkg::QUEUE_DEPTH];
  logic [bes_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [bes_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [bes_pkg::QUEUE_AW:0]   fill;

  assign full     = (fill == (bes_pkg::QUEUE_AW+1)'(bes_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bes_back.sv
// Back part: updates the statistics counters, owns the sample store and
// answers read items, with a registered result stage. Depends on bes_pkg.
`default_nettype none
module bes_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire bes_pkg::entry_t       q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       burst_closed,
  output logic [31:0]                closed_length,
  output logic [2:0]                 bucket_index,
  output logic                       burst_critical,
  output logic                       sample_stored,
  output logic                       sample_dropped_now,
  output logic [31:0]                current_length,
  output logic [47:0]                read_value
);

  localparam int CW = bes_pkg::CNT_W;

  logic [CW-1:0]             bin_counts [bes_pkg::NUM_BINS];
  logic [CW-1:0]             burst_total;
  logic [CW-1:0]             length_sum;
  logic [bes_pkg::LEN_W-1:0] longest_run;
  logic [CW-1:0]             recoverable_total;
  logic [CW-1:0]             critical_total;
  logic [CW-1:0]             symbol_total;
  logic [CW-1:0]             lost_total;
  logic [CW-1:0]             samples_discarded;
  logic [CW:0]               sum_wide;
  logic [CW-1:0]             counter_value;

  logic [bes_pkg::LEN_W-1:0] sample_store [bes_pkg::SAMPLE_DEPTH];
  logic [bes_pkg::LEN_W-1:0] sample_q;
  logic                      use_sample;
  logic [CW-1:0]             count_q;
  bes_pkg::entry_t           d;

  assign d     = q_data;
  assign q_pop = !q_empty && (!out_valid || out_ready);

  assign sum_wide = {1'b0, length_sum} + (CW+1)'(d.closed_length);

  always_comb begin
    counter_value = '0;
    if (d.counter_select <= bes_pkg::SEL_BIN_LAST) begin
      counter_value = bin_counts[d.counter_select[2:0]];
    end else begin
      case (d.counter_select)
        bes_pkg::SEL_BURSTS:      counter_value = burst_total;
        bes_pkg::SEL_SUM:         counter_value = length_sum;
        bes_pkg::SEL_LONGEST:     counter_value = CW'(longest_run);
        bes_pkg::SEL_RECOVERABLE: counter_value = recoverable_total;
        bes_pkg::SEL_CRITICAL:    counter_value = critical_total;
        bes_pkg::SEL_SYMBOLS:     counter_value = symbol_total;
        bes_pkg::SEL_LOST:        counter_value = lost_total;
        default:                  counter_value = '0;
      endcase
    end
  end

  // Sample store: one write or one registered read per item.
  always_ff @(posedge clk) begin
    if (q_pop && d.store) sample_store[d.store_addr] <= d.closed_length;
    if (q_pop && d.rd_sample) sample_q <= sample_store[d.sample_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bes_pkg::NUM_BINS; i++) bin_counts[i] <= '0;
      burst_total       <= '0;
      length_sum        <= '0;
      longest_run       <= '0;
      recoverable_total <= '0;
      critical_total    <= '0;
      symbol_total      <= '0;
      lost_total        <= '0;
      samples_discarded <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (q_pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        if (d.count_symbol && symbol_total != '1) symbol_total <= symbol_total + 1'b1;
        if (d.count_lost && lost_total != '1) lost_total <= lost_total + 1'b1;
        if (d.closed) begin
          if (burst_total != '1) burst_total <= burst_total + 1'b1;
          length_sum <= sum_wide[CW] ? '1 : sum_wide[CW-1:0];
          if (d.closed_length > longest_run) longest_run <= d.closed_length;
          for (int i = 0; i < bes_pkg::NUM_BINS; i++) begin
            if (d.bucket == 3'(i) && bin_counts[i] != '1) begin
              bin_counts[i] <= bin_counts[i] + 1'b1;
            end
          end
          if (d.critical) begin
            if (critical_total != '1) critical_total <= critical_total + 1'b1;
          end else if (recoverable_total != '1) begin
            recoverable_total <= recoverable_total + 1'b1;
          end
          if (d.drop && samples_discarded != '1) begin
            samples_discarded <= samples_discarded + 1'b1;
          end
        end
      end
    end
  end

  // Result register; the sample read data joins it at the output.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      burst_closed       <= d.closed;
      closed_length      <= d.closed_length;
      bucket_index       <= d.bucket;
      burst_critical     <= d.critical;
      sample_stored      <= d.store;
      sample_dropped_now <= d.drop;
      current_length     <= d.current_length;
      use_sample         <= d.rd_sample;
      count_q            <= d.rd_count ? counter_value : '0;
    end
  end

  assign read_value = use_sample ? 48'(sample_q) : count_q;

endmodule
`default_nettype wire

FILE: rtl/burst_error_statistics.sv
// Burst error statistics: measures runs of lost symbols, keeps counters, a
// histogram and a store of closed run lengths. Top level over bes_front,
// bes_queue and bes_back; depends on bes_pkg.
//
// Input items (in_valid/in_ready) carry an opcode: good symbol, lost
// symbol, close burst, read counter or read sample. Every item gives
// exactly one result item on out_valid/out_ready, in order.
// The user must write the correctable span register through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this. An accepted item
// passes through the queue and then the result register; one item per cycle
// is sustained while out_ready stays high. The front classifies an item in its
// accept cycle, a four-entry queue holds it, and the back, as it pops the item,
// updates counters and the sample store and registers the result.
// When the receiver stalls, the result register holds, the queue fills
// and in_ready drops once the queue has four items waiting.
// Synchronous reset clears all counters, the open run, the fill level of
// the sample store and the span register; stored samples are not cleared,
// as entries at or above the fill level read as zero.
`default_nettype none
module burst_error_statistics (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  counter_select,
  input  wire logic [11:0] sample_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             burst_closed,
  output logic [31:0]      closed_length,
  output logic [2:0]       bucket_index,
  output logic             burst_critical,
  output logic             sample_stored,
  output logic             sample_dropped_now,
  output logic [31:0]      current_length,
  output logic [47:0]      read_value
);

  bes_pkg::entry_t push_data;
  bes_pkg::entry_t pop_data;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  bes_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .counter_select (counter_select),
    .sample_index   (sample_index),
    .q_full         (full),
    .q_push         (push),
    .q_data         (push_data)
  );

  bes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  bes_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (empty),
    .q_data             (pop_data),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .burst_closed       (burst_closed),
    .closed_length      (closed_length),
    .bucket_index       (bucket_index),
    .burst_critical     (burst_critical),
    .sample_stored      (sample_stored),
    .sample_dropped_now (sample_dropped_now),
    .current_length     (current_length),
    .read_value         (read_value)
  );

endmodule
`default_nettype wire

FILE: bench/burst_stats_checker.sv
// Checker for the burst error statistics block: watches the config port and
// both item channels, predicts each result and compares it in order.
// Depends on bes_pkg for widths, opcodes, counter selects and bin edges.
module burst_stats_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  counter_select,
  input  wire logic [11:0] sample_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        burst_closed,
  input  wire logic [31:0] closed_length,
  input  wire logic [2:0]  bucket_index,
  input  wire logic        burst_critical,
  input  wire logic        sample_stored,
  input  wire logic        sample_dropped_now,
  input  wire logic [31:0] current_length,
  input  wire logic [47:0] read_value,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Field order matches the concatenation of the output ports below.
  typedef struct packed {
    logic                      closed;
    logic [bes_pkg::LEN_W-1:0] closed_len;
    logic [2:0]                bin;
    logic                      critical;
    logic                      stored;
    logic                      dropped;
    logic [bes_pkg::LEN_W-1:0] current;
    logic [bes_pkg::CNT_W-1:0] read;
  } stats_result_t;

  logic [bes_pkg::LEN_W-1:0]  span;
  logic [bes_pkg::LEN_W-1:0]  open_len;
  logic [bes_pkg::CNT_W-1:0]  bin_count [bes_pkg::NUM_BINS];
  logic [bes_pkg::CNT_W-1:0]  bursts;
  logic [bes_pkg::CNT_W-1:0]  len_sum;
  logic [bes_pkg::LEN_W-1:0]  longest;
  logic [bes_pkg::CNT_W-1:0]  recoverable;
  logic [bes_pkg::CNT_W-1:0]  critical_cnt;
  logic [bes_pkg::CNT_W-1:0]  symbols;
  logic [bes_pkg::CNT_W-1:0]  lost_syms;
  logic [bes_pkg::HELD_W-1:0] held;
  logic [bes_pkg::LEN_W-1:0]  stored_len [bes_pkg::SAMPLE_DEPTH];
  stats_result_t              expected_q [$];
  int                         mismatches;

  function automatic logic [bes_pkg::CNT_W-1:0] inc_sat(
      input logic [bes_pkg::CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [bes_pkg::CNT_W-1:0] add_len_sat(
      input logic [bes_pkg::CNT_W-1:0] acc, input logic [bes_pkg::LEN_W-1:0] len);
    logic [bes_pkg::CNT_W:0] s;
    s = {1'b0, acc} + (bes_pkg::CNT_W+1)'(len);
    return s[bes_pkg::CNT_W] ? '1 : s[bes_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [2:0] bin_for_length(input logic [bes_pkg::LEN_W-1:0] len);
    if (len <= bes_pkg::BIN0_TOP) return 3'd0;
    if (len <= bes_pkg::BIN1_TOP) return 3'd1;
    if (len <= bes_pkg::BIN2_TOP) return 3'd2;
    if (len <= bes_pkg::BIN3_TOP) return 3'd3;
    if (len <= bes_pkg::BIN4_TOP) return 3'd4;
    if (len <= bes_pkg::BIN5_TOP) return 3'd5;
    return 3'd6;
  endfunction

  // Closes the open run, if any, and updates every statistic it feeds.
  function automatic stats_result_t retire_open_run();
    stats_result_t r;
    logic [2:0]    b;
    r = '0;
    if (open_len != '0) begin
      b = bin_for_length(open_len);
      r.closed = 1'b1;
      r.closed_len = open_len;
      r.bin = b;
      bursts = inc_sat(bursts);
      len_sum = add_len_sat(len_sum, open_len);
      if (open_len > longest) longest = open_len;
      bin_count[b] = inc_sat(bin_count[b]);
      if (held < bes_pkg::HELD_W'(bes_pkg::SAMPLE_DEPTH)) begin
        stored_len[held[bes_pkg::SAMPLE_AW-1:0]] = open_len;
        held = held + 1'b1;
        r.stored = 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
      if (span != '0 && open_len > span) begin
        critical_cnt = inc_sat(critical_cnt);
        r.critical = 1'b1;
      end else begin
        recoverable = inc_sat(recoverable);
      end
      open_len = '0;
    end
    return r;
  endfunction

  function automatic logic [bes_pkg::CNT_W-1:0] counter_value(input logic [3:0] sel);
    if (sel <= bes_pkg::SEL_BIN_LAST) return bin_count[sel];
    case (sel)
      bes_pkg::SEL_BURSTS:      return bursts;
      bes_pkg::SEL_SUM:         return len_sum;
      bes_pkg::SEL_LONGEST:     return bes_pkg::CNT_W'(longest);
      bes_pkg::SEL_RECOVERABLE: return recoverable;
      bes_pkg::SEL_CRITICAL:    return critical_cnt;
      bes_pkg::SEL_SYMBOLS:     return symbols;
      bes_pkg::SEL_LOST:        return lost_syms;
      default:                  return '0;
    endcase
  endfunction

  function automatic stats_result_t predict_result(input logic [2:0] op,
      input logic [3:0] sel, input logic [bes_pkg::SAMPLE_AW-1:0] idx);
    stats_result_t r;
    r = '0;
    case (op)
      bes_pkg::OP_GOOD: begin
        symbols = inc_sat(symbols);
        r = retire_open_run();
      end
      bes_pkg::OP_LOST: begin
        symbols = inc_sat(symbols);
        lost_syms = inc_sat(lost_syms);
        if (open_len != '1) open_len = open_len + 1'b1;
      end
      bes_pkg::OP_CLOSE: r = retire_open_run();
      bes_pkg::OP_RD_COUNT: r.read = counter_value(sel);
      bes_pkg::OP_RD_SMP: begin
        if (bes_pkg::HELD_W'(idx) < held) r.read = bes_pkg::CNT_W'(stored_len[idx]);
      end
      default: ;
    endcase
    r.current = open_len;
    return r;
  endfunction

  function automatic string describe(input stats_result_t r);
    return {$sformatf("closed=%0b len=%0d bin=%0d crit=%0b ",
                      r.closed, r.closed_len, r.bin, r.critical),
            $sformatf("stored=%0b dropped=%0b cur=%0d read=%0d",
                      r.stored, r.dropped, r.current, r.read)};
  endfunction

  always @(posedge clk) begin : watch
    stats_result_t seen;
    stats_result_t want;
    if (rst) begin
      span = '0;
      open_len = '0;
      for (int i = 0; i < bes_pkg::NUM_BINS; i++) bin_count[i] = '0;
      bursts = '0;
      len_sum = '0;
      longest = '0;
      recoverable = '0;
      critical_cnt = '0;
      symbols = '0;
      lost_syms = '0;
      held = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      // Results are matched before this edge's new item is predicted.
      if (out_valid && out_ready) begin
        seen = {burst_closed, closed_length, bucket_index, burst_critical,
                sample_stored, sample_dropped_now, current_length, read_value};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item waiting: %s", $realtime, describe(seen));
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected %s", $realtime, describe(want));
              $display("%0t:           actual   %s", $realtime, describe(seen));
            end
          end
        end
      end
      if (cfg_we) span = cfg_wdata;
      if (in_valid && in_ready)
        expected_q.push_back(predict_result(opcode, counter_select, sample_index));
    end
    fail_count <= mismatches;
    pending <= expected_q.size();
  end

endmodule

FILE: bench/tb_burst_error_statistics.sv
// Top of the burst error statistics bench: clock, reset, span settings and
// item stimulus with random gaps and stalls. Depends on bes_pkg, the block
// and burst_stats_checker, which does all prediction and comparison.
module tb_burst_error_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block leaves unused.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam logic [3:0] SEL_SPARE_LO = 4'd14;
  localparam logic [3:0] SEL_SPARE_HI = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = bes_pkg::OP_GOOD;
  logic [3:0]  counter_select = '0;
  logic [11:0] sample_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        burst_closed;
  logic [31:0] closed_length;
  logic [2:0]  bucket_index;
  logic        burst_critical;
  logic        sample_stored;
  logic        sample_dropped_now;
  logic [31:0] current_length;
  logic [47:0] read_value;
  int          fail_count;
  int          pending;

  // Stimulus bookkeeping, so that sample reads only touch written entries.
  bit          run_open;
  int          held_count;
  int          items_sent;
  logic [31:0] span_now;
  int          quiet_items;
  int          stall_left;
  int          ready_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  burst_error_statistics u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .counter_select(counter_select), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .burst_closed(burst_closed),
    .closed_length(closed_length), .bucket_index(bucket_index),
    .burst_critical(burst_critical), .sample_stored(sample_stored),
    .sample_dropped_now(sample_dropped_now), .current_length(current_length),
    .read_value(read_value)
  );

  burst_stats_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .counter_select(counter_select), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .burst_closed(burst_closed),
    .closed_length(closed_length), .bucket_index(bucket_index),
    .burst_critical(burst_critical), .sample_stored(sample_stored),
    .sample_dropped_now(sample_dropped_now), .current_length(current_length),
    .read_value(read_value), .fail_count(fail_count), .pending(pending)
  );

  // Receiver: mostly ready, short and long stalls, and stretches of no stall.
  always @(posedge clk) begin : receiver
    int r;
    if (ready_quiet > 0) begin
      ready_quiet--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 999);
      if (r < 8) begin
        ready_quiet = $urandom_range(40, 150);
        out_ready <= 1'b1;
      end else if (r < 700) begin
        out_ready <= 1'b1;
      end else if (r < 960) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 8) begin
      quiet_items = $urandom_range(40, 150);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 940) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Returns right after the accepting edge; the caller must present the next
  // item or lower valid in that same step.
  task automatic send_item(input logic [2:0] op, input logic [3:0] sel,
                           input logic [11:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    counter_select <= sel;
    sample_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == bes_pkg::OP_LOST) begin
      run_open = 1'b1;
    end else if ((op == bes_pkg::OP_GOOD || op == bes_pkg::OP_CLOSE) && run_open) begin
      run_open = 1'b0;
      held_count++;
    end
    if (op <= bes_pkg::OP_RD_SMP) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_span(input logic [31:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_now = v;
  endtask

  task automatic send_sample_read();
    int         top_idx;
    int         r;
    logic [11:0] idx;
    if (held_count == 0) begin
      send_item(bes_pkg::OP_RD_COUNT, 4'($urandom), 12'($urandom));
      return;
    end
    top_idx = (held_count < bes_pkg::SAMPLE_DEPTH) ? held_count - 1
                                                   : bes_pkg::SAMPLE_DEPTH - 1;
    r = $urandom_range(0, 9);
    if (r < 2) idx = '0;
    else if (r < 4) idx = 12'(top_idx);
    else idx = 12'($urandom_range(0, top_idx));
    send_item(bes_pkg::OP_RD_SMP, 4'($urandom), idx);
  endtask

  task automatic send_read();
    if ($urandom_range(0, 1) == 0)
      send_item(bes_pkg::OP_RD_COUNT, 4'($urandom_range(0, 15)), 12'($urandom));
    else
      send_sample_read();
  endtask

  task automatic send_noise();
    logic [2:0] op;
    op = 3'($urandom_range(0, 7));
    if (op == bes_pkg::OP_RD_SMP) send_sample_read();
    else send_item(op, 4'($urandom), 12'($urandom));
  endtask

  // One burst: up to two good symbols, a run of lost ones with the occasional
  // random-opcode item inside, then a good symbol or a close, sometimes a read.
  task automatic send_burst();
    int edges [10] = '{1, 2, 5, 6, 10, 11, 50, 51, 100, 101};
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) len = $urandom_range(1, 12);
    else if (r < 80) len = edges[$urandom_range(0, 9)];
    else if (r < 83) len = 499 + $urandom_range(0, 3);
    else if (r < 95 && span_now != 0 && span_now <= 600)
      len = int'(span_now) + $urandom_range(0, 1);
    else len = $urandom_range(13, 120);
    repeat ($urandom_range(0, 2))
      send_item(bes_pkg::OP_GOOD, 4'($urandom), 12'($urandom));
    repeat (len) begin
      send_item(bes_pkg::OP_LOST, 4'($urandom), 12'($urandom));
      if ($urandom_range(0, 99) < 3) send_noise();
    end
    if ($urandom_range(0, 9) < 6) send_item(bes_pkg::OP_GOOD, 4'($urandom), 12'($urandom));
    else send_item(bes_pkg::OP_CLOSE, 4'($urandom), 12'($urandom));
    if ($urandom_range(0, 9) < 3) send_read();
  endtask

  task automatic run_random(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 72) send_burst();
      else if (r < 75) wait_idle();
      else send_noise();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the span still at its reset value of zero.
    send_item(bes_pkg::OP_CLOSE, '0, '0);      // close with no open run
    send_item(bes_pkg::OP_GOOD, '1, '1);       // good symbol, no run
    send_item(bes_pkg::OP_LOST, '0, '0);
    send_item(bes_pkg::OP_GOOD, '0, '0);       // run of one
    send_item(bes_pkg::OP_LOST, '1, '1);
    send_item(bes_pkg::OP_LOST, '0, '0);
    send_item(bes_pkg::OP_CLOSE, '1, '1);      // run of two by command
    send_item(bes_pkg::OP_LOST, '0, '0);
    send_item(OP_SPARE_LO, '1, '1);            // spare opcodes leave the run open
    send_item(OP_SPARE_HI, '0, '0);
    send_item(bes_pkg::OP_CLOSE, '0, '1);
    send_item(bes_pkg::OP_RD_SMP, '1, '0);
    send_item(bes_pkg::OP_RD_SMP, '0, 12'd2);
    send_item(bes_pkg::OP_RD_COUNT, 4'd0, '1);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_BIN_LAST, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_BURSTS, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_SUM, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_LONGEST, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_RECOVERABLE, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_CRITICAL, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_SYMBOLS, '0);
    send_item(bes_pkg::OP_RD_COUNT, bes_pkg::SEL_LOST, '0);
    send_item(bes_pkg::OP_RD_COUNT, SEL_SPARE_LO, '0);
    send_item(bes_pkg::OP_RD_COUNT, SEL_SPARE_HI, '1);

    write_span(32'd1);
    run_random(260);
    write_span(32'hFFFF_FFFF);
    run_random(260);
    write_span(32'($urandom_range(2, 60)));
    run_random(260);
    write_span(32'd0);
    run_random(260);
    write_span(32'($urandom_range(100, 600)));
    run_random(260);
    write_span($urandom());
    run_random(260);
    write_span(32'($urandom_range(1, 20)));
    run_random(200);

    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS burst_error_statistics");
    end else begin
      $display("FAIL burst_error_statistics");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL burst_error_statistics");
    $finish;
  end

endmodule
